// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the checker of the running median filter.
// No dependencies; included by the checker file only.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is held.
`define RMF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("running median filter check failed");

// Next-cycle implication, switched off while reset is held.
`define RMF_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("running median filter check failed");

// Next-cycle implication that also holds across reset.
`define RMF_ASSERT_NXT_NR(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("running median filter check failed");

`endif

// ===== hdl/rmf_pkg.sv =====
// Constants and types of the running median filter.
// No dependencies; used by every other file of the block but assert_macros.svh.
package rmf_pkg;

  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int MAX_WINDOW_DEF   = 15;

  // Width of the window length register and its limits.
  localparam int CFG_W     = 4;
  localparam int CFG_MAX   = 15;
  localparam int WIN_MIN   = 3;
  localparam int WIN_RESET = 5;

  // Control from the sequencer to the history line.
  typedef struct packed {
    logic push;     // take the sample of the accepted beat
    logic seq_end;  // the sequence is finished, restart the count
  } hist_ctl_t;

  // Control from the sequencer to the row of sorting cells.
  typedef struct packed {
    logic insert;   // insert the offered value this cycle
    logic clear;    // forget the old contents before inserting
  } sort_ctl_t;

endpackage

// ===== hdl/rmf_in_if.sv =====
// Input channel of the running median filter: one sample and its end flag.
// Depends on rmf_pkg for the default sample width.
interface rmf_in_if #(
  parameter int SAMPLE_WIDTH = rmf_pkg::SAMPLE_WIDTH_DEF
) ();
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample;
  logic                           final_sample;

  modport source (output valid, output sample, output final_sample, input ready);
  modport sink (input valid, input sample, input final_sample, output ready);
endinterface

// ===== hdl/rmf_out_if.sv =====
// Result channel of the running median filter: one median and its end flag.
// Depends on rmf_pkg for the default sample width.
interface rmf_out_if #(
  parameter int SAMPLE_WIDTH = rmf_pkg::SAMPLE_WIDTH_DEF
) ();
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] median;
  logic                           final_result;

  modport source (output valid, output median, output final_result, input ready);
  modport sink (input valid, input median, input final_result, output ready);
endinterface

// ===== hdl/rmf_hist.sv =====
// Sample history of the running median filter: shift line, first sample, count.
// Depends on rmf_pkg for the control struct.
module rmf_hist #(
  parameter int DEPTH = rmf_pkg::MAX_WINDOW_DEF,
  parameter int W     = rmf_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  rmf_pkg::hist_ctl_t          ctl,
  input  logic signed [W-1:0]         sample,
  input  logic [$clog2(DEPTH)-1:0]    tap_off,
  output logic signed [W-1:0]         tap_val,
  output logic [$clog2(DEPTH+1)-1:0]  seen_push
);

  localparam int SW = $clog2(DEPTH + 1);

  logic signed [W-1:0] hist_r [DEPTH];
  logic signed [W-1:0] first_r;
  logic [SW-1:0]       seen_r;

  // Count of samples in the sequence once this beat is taken, saturating.
  assign seen_push = (seen_r == SW'(DEPTH)) ? seen_r : seen_r + SW'(1);

  // Taps older than the start of the sequence repeat the first sample.
  assign tap_val = (SW'(tap_off) >= seen_r) ? first_r : hist_r[tap_off];

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      hist_r[0] <= sample;
      for (int k = 1; k < DEPTH; k++) begin
        hist_r[k] <= hist_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push && (seen_r == '0)) begin
      first_r <= sample;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= '0;
    end else if (ctl.push) begin
      seen_r <= seen_push;
    end else if (ctl.seq_end) begin
      seen_r <= '0;
    end
  end

endmodule

// ===== hdl/rmf_sort_cell.sv =====
// One cell of the sorted row: holds one value and passes it on when displaced.
// Depends on rmf_pkg for the control struct.
module rmf_sort_cell #(
  parameter int W = rmf_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  rmf_pkg::sort_ctl_t  ctl,
  input  logic signed [W-1:0] x,
  input  logic signed [W-1:0] prev_val,
  input  logic                prev_valid,
  input  logic                prev_gt,
  output logic signed [W-1:0] val_o,
  output logic                valid_o,
  output logic                gt_o
);

  logic signed [W-1:0] val_r, val_nxt;
  logic                valid_r, valid_nxt;
  logic                eff_valid;

  // A clear empties the row in the same cycle as the first insert.
  assign eff_valid = valid_r & ~ctl.clear;
  assign gt_o      = !eff_valid || (val_r > x);
  assign val_o     = val_r;
  assign valid_o   = eff_valid;

  always_comb begin
    val_nxt   = val_r;
    valid_nxt = eff_valid;
    if (ctl.insert && gt_o) begin
      if (!prev_gt) begin
        val_nxt   = x;
        valid_nxt = 1'b1;
      end else begin
        val_nxt   = prev_val;
        valid_nxt = prev_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

// ===== hdl/rmf_sort_chain.sv =====
// Row of sorting cells kept in ascending order, with a select of one rank.
// Depends on rmf_pkg and rmf_sort_cell.
module rmf_sort_chain #(
  parameter int NCELL = rmf_pkg::CFG_MAX,
  parameter int W     = rmf_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  rmf_pkg::sort_ctl_t         ctl,
  input  logic signed [W-1:0]        x,
  input  logic [$clog2(NCELL)-1:0]   sel,
  output logic signed [W-1:0]        median
);

  logic signed [W-1:0] val_w   [NCELL];
  logic                valid_w [NCELL];
  logic                gt_w    [NCELL];

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    if (i == 0) begin : g_head
      rmf_sort_cell #(.W(W)) u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .x          (x),
        .prev_val   ('0),
        .prev_valid (1'b0),
        .prev_gt    (1'b0),
        .val_o      (val_w[i]),
        .valid_o    (valid_w[i]),
        .gt_o       (gt_w[i])
      );
    end else begin : g_body
      rmf_sort_cell #(.W(W)) u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .x          (x),
        .prev_val   (val_w[i-1]),
        .prev_valid (valid_w[i-1]),
        .prev_gt    (gt_w[i-1]),
        .val_o      (val_w[i]),
        .valid_o    (valid_w[i]),
        .gt_o       (gt_w[i])
      );
    end
  end

  assign median = val_w[sel];

endmodule

// ===== hdl/running_median_filter_1d.sv =====
// Top level of the running median filter: sequencer, history and sorted cell row.
// Depends on rmf_pkg, rmf_in_if, rmf_out_if, rmf_hist and rmf_sort_chain.
//
//   channel  | direction | beat carries
//   ---------+-----------+------------------------------
//   in_ch    | in        | sample, final_sample
//   out_ch   | out       | median, final_result
//   cfg_wr_* | in        | window_size, no handshake
//
// A beat that yields no result leaves the sequencer idle. Each result is built after
// the beat by one insert per window element into the cell row, then a move of the
// chosen rank into the output register, once that register is free.
// A final beat drains up to window_size/2 + 1 results back to back in this way.
// Reset is synchronous and needs no clearing pass. in_ch.ready stays low from a
// beat until its last result sits in the output register, which holds under stall.
module running_median_filter_1d #(
  parameter int MAX_WINDOW   = rmf_pkg::MAX_WINDOW_DEF,
  parameter int SAMPLE_WIDTH = rmf_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [rmf_pkg::CFG_W-1:0] cfg_wr_data,
  rmf_in_if.sink                    in_ch,
  rmf_out_if.source                 out_ch
);

  localparam int CFG_W   = rmf_pkg::CFG_W;
  localparam int MAX_ODD = MAX_WINDOW - 1 + (MAX_WINDOW % 2);
  localparam int WIN_CAP = (MAX_ODD < rmf_pkg::CFG_MAX) ? MAX_ODD : rmf_pkg::CFG_MAX;
  localparam int WIN_RST = (rmf_pkg::WIN_RESET < WIN_CAP) ? rmf_pkg::WIN_RESET : WIN_CAP;
  localparam int OW      = $clog2(MAX_WINDOW);
  localparam int SW      = $clog2(MAX_WINDOW + 1);
  localparam int HW      = CFG_W - 1;
  localparam int IW      = $clog2(WIN_CAP);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOAD = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [CFG_W-1:0] win_r, win_nxt;
  logic             final_r, final_nxt;
  logic [HW-1:0]    d_r, d_nxt;
  logic [OW-1:0]    off_r, off_nxt;
  logic [CFG_W-1:0] cnt_r, cnt_nxt;
  logic             first_r, first_nxt;

  logic                           out_valid_r;
  logic signed [SAMPLE_WIDTH-1:0] median_r;
  logic                           final_result_r;
  logic                           out_load;

  logic [HW-1:0]                  half;
  logic [HW-1:0]                  d_start;
  logic [SW-1:0]                  seen_push;
  logic signed [SAMPLE_WIDTH-1:0] tap_val;
  logic signed [SAMPLE_WIDTH-1:0] median_w;
  rmf_pkg::hist_ctl_t             hist_ctl;
  rmf_pkg::sort_ctl_t             sort_ctl;

  assign half = win_r[CFG_W-1:1];

  // A final beat on a short sequence starts at its oldest pending position.
  assign d_start = (in_ch.final_sample && (int'(half) > int'(seen_push) - 1))
                   ? HW'(seen_push - SW'(1)) : half;

  // Window writes are forced odd and kept within the supported range.
  always_comb begin
    win_nxt = win_r;
    if (cfg_wr_en) begin
      win_nxt = cfg_wr_data | CFG_W'(1);
      if (win_nxt < CFG_W'(rmf_pkg::WIN_MIN)) begin
        win_nxt = CFG_W'(rmf_pkg::WIN_MIN);
      end else if (win_nxt > CFG_W'(WIN_CAP)) begin
        win_nxt = CFG_W'(WIN_CAP);
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    final_nxt = final_r;
    d_nxt     = d_r;
    off_nxt   = off_r;
    cnt_nxt   = cnt_r;
    first_nxt = first_r;
    hist_ctl  = '0;
    sort_ctl  = '0;
    out_load  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          hist_ctl.push = 1'b1;
          final_nxt     = in_ch.final_sample;
          if (in_ch.final_sample || (int'(seen_push) > int'(half))) begin
            d_nxt     = d_start;
            off_nxt   = OW'(d_start) + OW'(half);
            cnt_nxt   = win_r - CFG_W'(1);
            first_nxt = 1'b1;
            state_nxt = ST_LOAD;
          end
        end
      end
      ST_LOAD: begin
        sort_ctl.insert = 1'b1;
        sort_ctl.clear  = first_r;
        first_nxt       = 1'b0;
        off_nxt         = (off_r == '0) ? off_r : off_r - OW'(1);
        cnt_nxt         = cnt_r - CFG_W'(1);
        if (cnt_r == '0) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load = 1'b1;
          if (final_r && (d_r != '0)) begin
            d_nxt     = d_r - HW'(1);
            off_nxt   = OW'(d_r - HW'(1)) + OW'(half);
            cnt_nxt   = win_r - CFG_W'(1);
            first_nxt = 1'b1;
            state_nxt = ST_LOAD;
          end else begin
            hist_ctl.seq_end = final_r;
            state_nxt        = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      win_r   <= CFG_W'(WIN_RST);
      first_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      win_r   <= win_nxt;
      first_r <= first_nxt;
    end
  end

  always_ff @(posedge clk) begin
    final_r <= final_nxt;
    d_r     <= d_nxt;
    off_r   <= off_nxt;
    cnt_r   <= cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      median_r       <= median_w;
      final_result_r <= final_r && (d_r == '0);
    end
  end

  rmf_hist #(
    .DEPTH (MAX_WINDOW),
    .W     (SAMPLE_WIDTH)
  ) u_hist (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (hist_ctl),
    .sample    (in_ch.sample),
    .tap_off   (off_r),
    .tap_val   (tap_val),
    .seen_push (seen_push)
  );

  rmf_sort_chain #(
    .NCELL (WIN_CAP),
    .W     (SAMPLE_WIDTH)
  ) u_sort (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (sort_ctl),
    .x      (tap_val),
    .sel    (IW'(half)),
    .median (median_w)
  );

  assign in_ch.ready         = (state_r == ST_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.median       = median_r;
  assign out_ch.final_result = final_result_r;

endmodule

// ===== hdl/rmf_checker.sv =====
// Port-level checks of the running median filter, bound to its top level.
// Depends on assert_macros.svh and rmf_pkg.
`include "assert_macros.svh"

module rmf_checker #(
  parameter int SAMPLE_WIDTH = rmf_pkg::SAMPLE_WIDTH_DEF
) (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    in_final_sample,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [SAMPLE_WIDTH-1:0] out_median,
  input logic                    out_final_result
);

  // A stalled result beat stays offered and unchanged.
  `RMF_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  `RMF_ASSERT_NXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(out_median) && $stable(out_final_result))

  // The last beat of a sequence always leaves results to drain.
  `RMF_ASSERT_NXT(a_final_busy, clk, rst_n, in_valid && in_ready && in_final_sample, !in_ready)

  // Out of reset the block is empty and ready for a beat.
  `RMF_ASSERT_NXT_NR(a_reset_idle, clk, !rst_n, in_ready && !out_valid)

endmodule

bind running_median_filter_1d rmf_checker #(
  .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_rmf_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .in_final_sample  (in_ch.final_sample),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_median       (out_ch.median),
  .out_final_result (out_ch.final_result)
);

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench of the running median filter: bursty sample driver, stalling
// result monitor and a bit-exact predictor of the clamped odd-window median.
// Depends on rmf_pkg, rmf_in_if, rmf_out_if and running_median_filter_1d.
`timescale 1ns / 100ps

module tb_top;

  localparam int SW           = rmf_pkg::SAMPLE_WIDTH_DEF;
  localparam int MAX_W        = rmf_pkg::MAX_WINDOW_DEF;
  localparam int MAX_ODD      = MAX_W - (1 - (MAX_W % 2));
  localparam int SMIN         = -(2 ** (SW - 1));
  localparam int SMAX         = 2 ** (SW - 1) - 1;
  localparam int LONG_HOLD    = 300;
  localparam int SETTLE_GAP   = MAX_W + 8;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_BEATS = 70;

  typedef struct {
    logic signed [SW-1:0] value;
    logic                 is_final;
  } sample_beat_t;

  typedef struct {
    logic signed [SW-1:0] median;
    logic                 is_final;
  } median_beat_t;

  logic                        clk;
  logic                        rst_n;
  logic                        cfg_wr_en;
  logic [rmf_pkg::CFG_W-1:0]   cfg_wr_data;

  rmf_in_if  #(.SAMPLE_WIDTH(SW)) in_ch ();
  rmf_out_if #(.SAMPLE_WIDTH(SW)) out_ch ();

  running_median_filter_1d #(
    .MAX_WINDOW  (MAX_W),
    .SAMPLE_WIDTH(SW)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_ch      (in_ch),
    .out_ch     (out_ch)
  );

  sample_beat_t sample_backlog[$];
  median_beat_t expected_medians[$];
  median_beat_t oldest_median;
  int           errors = 0;
  int           cycle_cnt = 0;
  int           burst_left;
  int           gap_left;
  int           hold_requests = 0;
  int           hold_served = 0;
  int           hold_left;
  int           stall_tick;

  // Predictor state: newest sample at index zero.
  logic signed [SW-1:0] hist_taps[MAX_W];
  logic signed [SW-1:0] first_val;
  int                   seen_cnt;
  int                   win_len;

  initial clk = 1'b0;
  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic logic signed [SW-1:0] tap_at(int off);
    if (off < 0) off = 0;
    if (off >= seen_cnt || off >= MAX_W) return first_val;
    return hist_taps[off];
  endfunction

  function automatic logic signed [SW-1:0] window_median(int centre, int half);
    logic signed [SW-1:0] win[MAX_W];
    logic signed [SW-1:0] key;
    int n;
    int b;
    n = 0;
    for (int j = -half; j <= half && n < MAX_W; j++) begin
      win[n] = tap_at(centre - j);
      n++;
    end
    for (int a = 1; a < n; a++) begin
      key = win[a];
      b = a - 1;
      while (b >= 0 && win[b] > key) begin
        win[b + 1] = win[b];
        b--;
      end
      win[b + 1] = key;
    end
    return win[n / 2];
  endfunction

  task automatic predict_beat(logic signed [SW-1:0] s, logic fin);
    int half;
    int start;
    half = win_len / 2;
    if (seen_cnt == 0) first_val = s;
    for (int k = MAX_W - 1; k > 0; k--) hist_taps[k] = hist_taps[k - 1];
    hist_taps[0] = s;
    if (seen_cnt < MAX_W) seen_cnt++;
    if (!fin) begin
      if (seen_cnt > half) expected_medians.push_back('{window_median(half, half), 1'b0});
    end else begin
      // The closing beat drains every position that is still owed.
      start = (half > seen_cnt - 1) ? seen_cnt - 1 : half;
      for (int d = start; d >= 0; d--)
        expected_medians.push_back('{window_median(d, half), (d == 0)});
      seen_cnt = 0;
    end
  endtask

  // Sender: bursts of random length with random gaps, holding each beat until taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid        <= 1'b0;
      in_ch.sample       <= '0;
      in_ch.final_sample <= 1'b0;
      burst_left = 1;
      gap_left   = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_beat(in_ch.sample, in_ch.final_sample);
        void'(sample_backlog.pop_front());
      end
      if (!(in_ch.valid && !in_ch.ready)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_ch.valid <= 1'b0;
        end else if (sample_backlog.size() > 0) begin
          in_ch.valid        <= 1'b1;
          in_ch.sample       <= sample_backlog[0].value;
          in_ch.final_sample <= sample_backlog[0].is_final;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 12);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: cycles through always-ready, random and sparse patterns, with an
  // occasional long hold-off so that the filter backs up into its input.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      hold_left  = 0;
      stall_tick = 0;
    end else begin
      stall_tick++;
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (hold_served != hold_requests) begin
        hold_served++;
        hold_left = LONG_HOLD;
        out_ch.ready <= 1'b0;
      end else begin
        case ((stall_tick / 64) % 3)
          0:       out_ch.ready <= 1'b1;
          1:       out_ch.ready <= $urandom_range(0, 1);
          default: out_ch.ready <= (stall_tick % 4 == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_medians.size() == 0) begin
        errors++;
        $display("%0t: median beat with none expected, got median %0d final %0b",
                 $time, out_ch.median, out_ch.final_result);
      end else begin
        oldest_median = expected_medians.pop_front();
        if (oldest_median.median !== out_ch.median) begin
          errors++;
          $display("%0t: median mismatch, expected %0d, got %0d",
                   $time, oldest_median.median, out_ch.median);
        end
        if (oldest_median.is_final !== out_ch.final_result) begin
          errors++;
          $display("%0t: final_result mismatch, expected %0b, got %0b",
                   $time, oldest_median.is_final, out_ch.final_result);
        end
      end
    end
  end

  function automatic logic signed [SW-1:0] pick_sample();
    int r;
    r = $urandom_range(0, 19);
    if (r < 12) return SW'($urandom);
    // Narrow values give plenty of ties inside the window.
    if (r < 17) return SW'($urandom_range(0, 8) - 4);
    case ($urandom_range(0, 3))
      0:       return SW'(SMIN);
      1:       return SW'(SMAX);
      2:       return '0;
      default: return '1;
    endcase
  endfunction

  task automatic queue_beat(int value, logic fin);
    sample_backlog.push_back('{SW'(value), fin});
  endtask

  task automatic queue_sequence(int len, bit close);
    for (int i = 0; i < len; i++)
      sample_backlog.push_back('{pick_sample(), close && (i == len - 1)});
  endtask

  task automatic settle();
    do @(negedge clk);
    while (sample_backlog.size() != 0 || in_ch.valid || expected_medians.size() != 0);
    // A beat that owes no median may still be in flight.
    repeat (SETTLE_GAP) @(negedge clk);
  endtask

  task automatic write_window(int value);
    int v;
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= rmf_pkg::CFG_W'(value);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    v = (value & rmf_pkg::CFG_MAX) | 1;
    if (v < rmf_pkg::WIN_MIN) v = rmf_pkg::WIN_MIN;
    if (v > MAX_ODD) v = MAX_ODD;
    win_len = v;
  endtask

  initial begin
    int fed;
    int nseq;
    int len;
    int phase;
    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    for (int k = 0; k < MAX_W; k++) hist_taps[k] = '0;
    first_val = '0;
    seen_cnt  = 0;
    win_len   = (rmf_pkg::WIN_RESET > MAX_ODD) ? MAX_ODD : rmf_pkg::WIN_RESET;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Reset window: one-beat sequence, two-beat sequence, then extremes.
    queue_beat(SMAX, 1'b1);
    queue_beat(SMIN, 1'b0);
    queue_beat(SMAX, 1'b1);
    queue_beat(0, 1'b0);
    queue_beat(-1, 1'b0);
    queue_beat(1, 1'b0);
    queue_beat(SMIN, 1'b0);
    queue_beat(SMAX, 1'b0);
    queue_beat(7, 1'b1);
    settle();

    // Zero rounds up to the smallest window.
    write_window(0);
    queue_beat(SMAX, 1'b0);
    queue_beat(SMIN, 1'b0);
    queue_beat(SMAX, 1'b0);
    queue_beat(SMIN, 1'b1);
    settle();

    // Widest window: a short sequence drains fewer than half+1 medians, then the
    // window shrinks part-way through a sequence.
    write_window(rmf_pkg::CFG_MAX);
    queue_beat(3, 1'b0);
    queue_beat(SMIN, 1'b0);
    queue_beat(SMAX, 1'b1);
    queue_sequence(9, 1'b0);
    settle();
    write_window(4);
    queue_sequence(3, 1'b1);
    settle();

    fed   = 0;
    phase = 0;
    while (fed < RANDOM_BEATS) begin
      write_window($urandom_range(0, rmf_pkg::CFG_MAX));
      if (phase == 0 || $urandom_range(0, 3) == 0) hold_requests++;
      nseq = $urandom_range(1, 3);
      for (int q = 0; q < nseq; q++) begin
        case ($urandom_range(0, 9))
          0, 1:    len = $urandom_range(1, 3);
          2:       len = $urandom_range(17, 24);
          default: len = $urandom_range(4, 16);
        endcase
        // Now and then the phase ends inside a sequence, so the next window
        // setting lands mid-sequence.
        queue_sequence(len, !(q == nseq - 1 && $urandom_range(0, 4) == 0));
        fed += len;
      end
      settle();
      phase++;
    end

    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
